>>> rtl/lsc_pkg.sv
// Shared types, codes and widths for the spike cascade engine.
package lsc_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_REST_LEVEL    = 3'd0,
    REG_FIRE_LEVEL    = 3'd1,
    REG_LEAK_GAIN     = 3'd2,
    REG_DEAD_TIME_US  = 3'd3,
    REG_SIGNAL_NEURON = 3'd4
  } reg_index_t;

  // Item kinds
  localparam logic KIND_INJECT = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  localparam int CFG_W        = 16;
  localparam int IDX_W        = 10;
  localparam int FIRE_COUNT_W = 11;
  localparam logic [FIRE_COUNT_W-1:0] FIRE_COUNT_MAX = '1;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  neuron_index;
    logic [31:0]       time_us;
    logic [3:0]        slot;
    logic [IDX_W-1:0]  target_index;
    logic signed [15:0] weight;
    logic              slot_valid;
  } in_word_t;

  typedef struct packed {
    logic                    trade_signal;
    logic [FIRE_COUNT_W-1:0] fire_count;
  } out_word_t;

  // Stored synapse slot
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   target;
    logic signed [15:0] weight;
  } syn_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POP,
    ST_POPW,
    ST_SREAD,
    ST_SWAIT,
    ST_UPD,
    ST_APPLY
  } state_t;

endpackage

>>> rtl/lsc_if.sv
// Valid/ready channels for input and result words.
interface lsc_in_if;
  import lsc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lsc_out_if;
  import lsc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/lif_spike_cascade_engine_unit.sv
// Leaky integrate-and-fire spike cascade engine: sequencer over four RAMs.
//
// After reset the block sweeps the synapse, potential and refractory RAMs over
// all NEURON_COUNT*MAX_FANOUT synapse addresses (16384 by default) and takes no
// word until done. A synapse write is done in the cycle its word is taken. An
// inject pops neurons from the spike queue and reads each one's synapse slots;
// a refractory target adds a potential/deadline RAM read and an integrated one
// a read-modify-write. One word is in work at a time; the result word waits in
// an output register.
module lif_spike_cascade_engine_unit #(
  parameter int NEURON_COUNT = 1024,
  parameter int MAX_FANOUT   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [lsc_pkg::CFG_W-1:0]   cfg_data,
  lsc_in_if.sink                      in_ch,
  lsc_out_if.source                   out_ch
);
  import lsc_pkg::*;

  localparam int NA_W     = $clog2(NEURON_COUNT);
  localparam int SYN_DEP  = NEURON_COUNT * MAX_FANOUT;
  localparam int SYN_AW   = $clog2(SYN_DEP);
  localparam int SLOT_W   = (MAX_FANOUT > 1) ? $clog2(MAX_FANOUT) : 1;
  localparam int SYN_W    = $bits(syn_word_t);

  // Configuration registers
  logic signed [15:0] rest_level, fire_level;
  logic [7:0]         leak_gain;
  logic [15:0]        dead_time_us;
  logic [IDX_W-1:0]   signal_neuron;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_level    <= -16'sd16640;
      fire_level    <= -16'sd12800;
      leak_gain     <= 8'd230;
      dead_time_us  <= 16'd2000;
      signal_neuron <= 10'd999;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REST_LEVEL:    rest_level    <= cfg_data;
        REG_FIRE_LEVEL:    fire_level    <= cfg_data;
        REG_LEAK_GAIN:     leak_gain     <= cfg_data[7:0];
        REG_DEAD_TIME_US:  dead_time_us  <= cfg_data;
        REG_SIGNAL_NEURON: signal_neuron <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers
  state_t               state, state_next;
  logic [SYN_AW-1:0]    clr_cnt;
  logic [NA_W:0]        head, tail;
  logic [NA_W-1:0]      nrn, tgt;
  logic [SLOT_W-1:0]    slot_k;
  logic signed [15:0]   wgt;
  logic [31:0]          now_us;
  logic signed [24:0]   prod;
  logic [FIRE_COUNT_W-1:0] fired;
  logic                 trade;
  logic                 out_valid;
  out_word_t            out_data;

  // RAM ports
  logic                 syn_we, pot_we, ref_we, q_we;
  logic [SYN_AW-1:0]    syn_waddr, syn_raddr;
  syn_word_t            syn_wdata, syn_rdata;
  logic [NA_W-1:0]      pot_waddr, pot_raddr, q_waddr, q_raddr;
  logic [15:0]          pot_wdata, pot_rdata;
  logic [31:0]          ref_wdata, ref_rdata;
  logic [NA_W-1:0]      q_wdata, q_rdata;

  lsc_ram #(.WIDTH(SYN_W), .DEPTH(SYN_DEP)) u_syn (
    .clk, .we(syn_we), .waddr(syn_waddr), .wdata(syn_wdata),
    .raddr(syn_raddr), .rdata(syn_rdata));
  lsc_ram #(.WIDTH(16), .DEPTH(NEURON_COUNT)) u_pot (
    .clk, .we(pot_we), .waddr(pot_waddr), .wdata(pot_wdata),
    .raddr(pot_raddr), .rdata(pot_rdata));
  lsc_ram #(.WIDTH(32), .DEPTH(NEURON_COUNT)) u_ref (
    .clk, .we(ref_we), .waddr(pot_waddr), .wdata(ref_wdata),
    .raddr(pot_raddr), .rdata(ref_rdata));
  lsc_ram #(.WIDTH(NA_W), .DEPTH(NEURON_COUNT)) u_q (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));

  // Handshake
  logic acc;
  assign in_ch.ready  = (state == ST_IDLE) && !out_valid;
  assign acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Decode helpers
  logic src_ok, wr_ok, last_k, tgt_ok, refr, fire, q_room;
  logic signed [16:0] s_leak;
  logic signed [18:0] sum;
  logic signed [15:0] v_sat;

  assign src_ok = 32'(in_ch.data.neuron_index) < NEURON_COUNT;
  assign wr_ok  = src_ok && (32'(in_ch.data.slot) < MAX_FANOUT);
  assign last_k = slot_k == SLOT_W'(MAX_FANOUT - 1);
  assign tgt_ok = syn_rdata.valid && (32'(syn_rdata.target) < NEURON_COUNT);
  assign refr   = now_us < ref_rdata;
  assign s_leak = 17'(prod >>> 8);
  assign sum    = 19'(rest_level) + 19'(s_leak) + 19'(wgt);
  assign v_sat  = (sum > 19'sd32767)  ? 16'sh7FFF :
                  (sum < -19'sd32768) ? 16'sh8000 : sum[15:0];
  assign fire   = v_sat >= fire_level;
  assign q_room = tail < (NA_W+1)'(NEURON_COUNT);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == SYN_AW'(SYN_DEP - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (acc && in_ch.data.kind == KIND_INJECT && src_ok) state_next = ST_POP;
      ST_POP:   state_next = (head == tail) ? ST_IDLE : ST_POPW;
      ST_POPW:  state_next = ST_SREAD;
      ST_SREAD: state_next = ST_SWAIT;
      ST_SWAIT: begin
        if (tgt_ok) state_next = ST_UPD;
        else        state_next = last_k ? ST_POP : ST_SREAD;
      end
      ST_UPD: begin
        if (refr) state_next = last_k ? ST_POP : ST_SREAD;
        else      state_next = ST_APPLY;
      end
      ST_APPLY: state_next = last_k ? ST_POP : ST_SREAD;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // RAM controls
  always_comb begin
    syn_we    = 1'b0;
    syn_waddr = SYN_AW'(32'(in_ch.data.neuron_index) * MAX_FANOUT + 32'(in_ch.data.slot));
    syn_wdata = '{valid: in_ch.data.slot_valid, target: in_ch.data.target_index,
                  weight: in_ch.data.weight};
    syn_raddr = SYN_AW'(32'(nrn) * MAX_FANOUT + 32'(slot_k));
    pot_we    = 1'b0;
    ref_we    = 1'b0;
    pot_waddr = tgt;
    pot_wdata = fire ? rest_level : v_sat;
    ref_wdata = now_us + 32'(dead_time_us);
    pot_raddr = NA_W'(syn_rdata.target);
    q_we      = 1'b0;
    q_waddr   = tail[NA_W-1:0];
    q_wdata   = tgt;
    q_raddr   = head[NA_W-1:0];
    case (state)
      ST_CLEAR: begin
        syn_we    = 1'b1;
        syn_waddr = clr_cnt;
        syn_wdata = '0;
        pot_waddr = NA_W'(clr_cnt);
        pot_wdata = '0;
        ref_wdata = '0;
        pot_we    = 32'(clr_cnt) < NEURON_COUNT;
        ref_we    = pot_we;
      end
      ST_IDLE: begin
        syn_we  = acc && in_ch.data.kind == KIND_WRITE && wr_ok;
        q_we    = acc && in_ch.data.kind == KIND_INJECT && src_ok;
        q_waddr = '0;
        q_wdata = NA_W'(in_ch.data.neuron_index);
      end
      ST_APPLY: begin
        pot_we = 1'b1;
        ref_we = fire;
        q_we   = fire && q_room;
      end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (acc) begin
            now_us <= in_ch.data.time_us;
            fired  <= '0;
            trade  <= 1'b0;
            head   <= '0;
            tail   <= (NA_W+1)'(1);
            if (in_ch.data.kind == KIND_WRITE || !src_ok) begin
              out_valid <= 1'b1;
              out_data  <= '0;
            end
          end
        end
        ST_POP: begin
          if (head == tail) begin
            out_valid <= 1'b1;
            out_data  <= '{trade_signal: trade, fire_count: fired};
          end else begin
            head <= head + 1'b1;
          end
        end
        ST_POPW: begin
          nrn    <= q_rdata;
          slot_k <= '0;
        end
        ST_SWAIT: begin
          tgt <= NA_W'(syn_rdata.target);
          wgt <= syn_rdata.weight;
          if (!tgt_ok) slot_k <= slot_k + 1'b1;
        end
        ST_UPD: begin
          prod <= 25'((17'(signed'(pot_rdata)) - 17'(rest_level)) * signed'({1'b0, leak_gain}));
          if (refr) slot_k <= slot_k + 1'b1;
        end
        ST_APPLY: begin
          slot_k <= slot_k + 1'b1;
          if (fire) begin
            if (fired != FIRE_COUNT_MAX) fired <= fired + 1'b1;
            if (32'(tgt) == 32'(signal_neuron)) trade <= 1'b1;
            if (q_room) tail <= tail + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= (NA_W+1)'(NEURON_COUNT)) else $error("queue tail past depth");
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE && state != ST_CLEAR |-> head <= tail)
    else $error("queue head passed tail");
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ch.ready) else $error("word taken during clear");
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    acc && in_ch.data.kind == KIND_WRITE |=> out_valid && out_data.fire_count == '0
    && !out_data.trade_signal) else $error("write word result wrong");

endmodule

>>> dv/lif_spike_cascade_engine_unit_tb.sv
// Self-checking testbench for the spike cascade engine: directed table plus random cascades.
module lif_spike_cascade_engine_unit_tb;
  import lsc_pkg::*;

  localparam int NEURONS = 1024;
  localparam int FANOUT  = 16;
  localparam int RAND_ITEMS = 1800;
  localparam longint CYCLE_LIMIT = 500000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  lsc_in_if  in_ch ();
  lsc_out_if out_ch ();

  lif_spike_cascade_engine_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Network mirror
  logic signed [15:0] pot_mem [NEURONS];
  logic [31:0]        dead_until [NEURONS];
  syn_word_t          syn_mem [NEURONS*FANOUT];
  logic [IDX_W-1:0]   fire_fifo [NEURONS];
  logic signed [15:0] m_rest, m_thr;
  logic [7:0]         m_leak;
  logic [15:0]        m_dead;
  logic [IDX_W-1:0]   m_sig;

  out_word_t expected_q [$];
  int  errors = 0;
  int  n_results = 0;
  int  n_fired_total = 0;
  int  n_trades = 0;
  longint cycles = 0;
  bit  hold_off = 1'b0;
  bit  hold_go = 1'b0;

  // Compute one result word and update the mirror
  function automatic out_word_t cascade_model(in_word_t w);
    out_word_t r;
    int head, tail, fired, d, v, p;
    syn_word_t s;
    logic [IDX_W-1:0] n, t;
    r = '0;
    fired = 0;
    if (w.kind == KIND_WRITE) begin
      syn_mem[w.neuron_index*FANOUT + w.slot] = '{valid: w.slot_valid,
        target: w.target_index, weight: w.weight};
      return r;
    end
    head = 0;
    tail = 1;
    fire_fifo[0] = w.neuron_index;
    while (head < tail) begin
      n = fire_fifo[head];
      head++;
      for (int k = 0; k < FANOUT; k++) begin
        s = syn_mem[n*FANOUT + k];
        t = s.target;
        if (!s.valid) continue;
        if (w.time_us < dead_until[t]) continue;
        d = int'(pot_mem[t]) - int'(m_rest);
        p = d * int'({1'b0, m_leak});
        v = int'(m_rest) + (p >>> 8) + int'(s.weight);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        if (v >= int'(m_thr)) begin
          pot_mem[t] = m_rest;
          dead_until[t] = w.time_us + {16'd0, m_dead};
          if (fired < 2047) fired++;
          if (t == m_sig) r.trade_signal = 1'b1;
          if (tail < NEURONS) begin
            fire_fifo[tail] = t;
            tail++;
          end
        end else begin
          pot_mem[t] = v[15:0];
        end
      end
    end
    r.fire_count = fired[FIRE_COUNT_W-1:0];
    return r;
  endfunction

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_REST_LEVEL:    m_rest = val;
      REG_FIRE_LEVEL:    m_thr  = val;
      REG_LEAK_GAIN:     m_leak = val[7:0];
      REG_DEAD_TIME_US:  m_dead = val;
      REG_SIGNAL_NEURON: m_sig  = val[IDX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] rest, logic [15:0] thr, logic [7:0] leak,
                            logic [15:0] dead, logic [9:0] sig);
    write_reg(REG_REST_LEVEL, rest);
    write_reg(REG_FIRE_LEVEL, thr);
    write_reg(REG_LEAK_GAIN, {8'd0, leak});
    write_reg(REG_DEAD_TIME_US, dead);
    write_reg(REG_SIGNAL_NEURON, {6'd0, sig});
  endtask

  // Offer one word; valid stays high across back-to-back words
  task automatic send_word(in_word_t w);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 1);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    expected_q = {expected_q, cascade_model(w)};
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  function automatic in_word_t syn_write(int src, int sl, int tgt, int wt, bit en);
    in_word_t w;
    w = '0;
    w.kind = KIND_WRITE;
    w.neuron_index = IDX_W'(src);
    w.slot = 4'(sl);
    w.target_index = IDX_W'(tgt);
    w.weight = 16'(wt);
    w.slot_valid = en;
    w.time_us = $urandom;
    return w;
  endfunction

  function automatic in_word_t inject(int src, logic [31:0] t);
    in_word_t w;
    w = '0;
    w.kind = KIND_INJECT;
    w.neuron_index = IDX_W'(src);
    w.time_us = t;
    w.slot = 4'($urandom);
    w.target_index = IDX_W'($urandom);
    w.weight = 16'($urandom);
    w.slot_valid = 1'($urandom);
    return w;
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: trade=%0d count=%0d",
               out_ch.data.trade_signal, out_ch.data.fire_count);
        errors++;
      end else begin
        exp_w = expected_q.pop_front();
        n_results++;
        n_fired_total += out_ch.data.fire_count;
        if (out_ch.data.trade_signal) n_trades++;
        if (out_ch.data.trade_signal !== exp_w.trade_signal) begin
          $error("trade_signal expected %0d actual %0d", exp_w.trade_signal,
                 out_ch.data.trade_signal);
          errors++;
        end
        if (out_ch.data.fire_count !== exp_w.fire_count) begin
          $error("fire_count expected %0d actual %0d", exp_w.fire_count,
                 out_ch.data.fire_count);
          errors++;
        end
      end
    end
  end

  // Receiver stalls: random gaps, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 19) == 0) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Long hold-off while words keep coming, counted here
  initial begin
    int hold;
    wait (hold_go);
    @(posedge clk);
    hold_off = 1'b1;
    for (hold = 0; hold < 600; hold++) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  typedef struct {
    in_word_t  w;
    bit        has_exp;
    out_word_t exp_w;
  } stim_row_t;

  stim_row_t dir_rows [$];

  function automatic void add_row(in_word_t w, bit has_exp, out_word_t exp_w);
    stim_row_t r;
    r.w = w;
    r.has_exp = has_exp;
    r.exp_w = exp_w;
    dir_rows = {dir_rows, r};
  endfunction

  // Random phase: synapse writes and injects mixed, mostly within a small subnet
  task automatic random_phase(int items, int base, int span, logic [31:0] t0);
    logic [31:0] now;
    int src;
    now = t0;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_word(syn_write(base + $urandom_range(0, span-1),
          $urandom_range(0, 15), base + $urandom_range(0, span-1),
          $urandom_range(0, 1) ? $urandom_range(0, 6000) : $urandom_range(0, 65535),
          $urandom_range(0, 5) != 0));
        4: send_word(syn_write($urandom_range(0, 1023), $urandom_range(0, 15),
          $urandom_range(0, 1023), $urandom, $urandom_range(0, 1) == 1));
        default: begin
          now = now + $urandom_range(0, 3000);
          if ($urandom_range(0, 30) == 0) now = $urandom;
          src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                           : base + $urandom_range(0, span-1);
          send_word(inject(src, now));
        end
      endcase
    end
    idle_input();
  endtask

  initial begin
    out_word_t got;
    for (int i = 0; i < NEURONS; i++) begin
      pot_mem[i] = '0;
      dead_until[i] = '0;
    end
    for (int i = 0; i < NEURONS*FANOUT; i++) syn_mem[i] = '0;
    m_rest = -16'sd16640;
    m_thr = -16'sd12800;
    m_leak = 8'd230;
    m_dead = 16'd2000;
    m_sig = 10'd999;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table; expected values only where obvious
    add_row(inject(0, 0), 1'b1, '{1'b0, 11'd0});
    add_row(inject(1023, 32'hFFFF_FFFF), 1'b1, '{1'b0, 11'd0});
    add_row(syn_write(0, 0, 999, 32767, 1'b1), 1'b1, '{1'b0, 11'd0});
    add_row(syn_write(1023, 15, 0, -32768, 1'b1), 1'b1, '{1'b0, 11'd0});
    add_row(syn_write(999, 15, 1023, 32767, 1'b1), 1'b1, '{1'b0, 11'd0});
    add_row(syn_write(1023, 0, 1023, 32767, 1'b0), 1'b1, '{1'b0, 11'd0});
    add_row(inject(0, 100), 1'b0, '{1'b0, 11'd0});
    add_row(inject(0, 200), 1'b0, '{1'b0, 11'd0});
    add_row(inject(0, 5000), 1'b0, '{1'b0, 11'd0});
    add_row(inject(1023, 5000), 1'b0, '{1'b0, 11'd0});
    add_row(inject(999, 32'hFFFF_FF00), 1'b0, '{1'b0, 11'd0});
    add_row(syn_write(5, 3, 6, 0, 1'b1), 1'b1, '{1'b0, 11'd0});
    add_row(inject(5, 32'hFFFF_FFFF), 1'b0, '{1'b0, 11'd0});
    add_row(inject(5, 10), 1'b0, '{1'b0, 11'd0});
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w);
      if (dir_rows[i].has_exp) begin
        got = expected_q[expected_q.size()-1];
        if (got !== dir_rows[i].exp_w) begin
          $error("directed row %0d: predictor expected %0d/%0d, table %0d/%0d", i,
                 got.trade_signal, got.fire_count,
                 dir_rows[i].exp_w.trade_signal, dir_rows[i].exp_w.fire_count);
          errors++;
        end
      end
    end
    idle_input();
    wait_drain();

    // Extreme settings: threshold at minimum so every non-refractory target fires, zero leak
    set_config(16'h0000, 16'h8000, 8'd0, 16'd1, 10'd6);
    send_word(inject(5, 20));
    send_word(inject(5, 20));
    send_word(inject(5, 21));
    idle_input();
    wait_drain();
    // Two self loops with no dead time: the queue fills and the count saturates
    write_reg(REG_DEAD_TIME_US, 16'd0);
    send_word(syn_write(7, 0, 7, 0, 1'b1));
    send_word(syn_write(7, 1, 7, 0, 1'b1));
    send_word(inject(7, 100));
    idle_input();
    wait_drain();
    set_config(16'h7FFF, 16'h7FFF, 8'd255, 16'd65535, 10'd1023);
    send_word(inject(3, 32'hFFFF_0000));
    send_word(inject(3, 32'hFFFF_FFFF));
    send_word(syn_write(7, 0, 0, 0, 1'b0));
    send_word(syn_write(7, 1, 0, 0, 1'b0));
    idle_input();
    wait_drain();

    // Random phases over several settings
    set_config(-16'sd16640, -16'sd12800, 8'd230, 16'd2000, 10'd40);
    hold_go = 1'b1;
    random_phase(RAND_ITEMS / 3, 32, 16, 32'd0);
    wait_drain();
    set_config(16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom_range(1, 65535)),
               10'($urandom_range(0, 63)));
    random_phase(RAND_ITEMS * 2 / 9, 0, 64, $urandom);
    wait_drain();
    set_config(-16'sd1000, 16'sd500, 8'd128, 16'd0, 10'd70);
    random_phase(RAND_ITEMS * 2 / 9, 64, 12, 32'd1000);
    wait_drain();
    set_config(16'h8000, 16'h8001, 8'd200, 16'd50, 10'd100);
    random_phase(RAND_ITEMS * 2 / 9, 96, 24, 32'hFFFF_F000);
    wait_drain();

    $display("Run covered %0d result words, %0d neuron firings, %0d trade flags.",
             n_results, n_fired_total, n_trades);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
